/* rtl/virtual_irq_priority_controller_unit_macros.svh */
// Assertion macros used by the checker file of the virtual IRQ controller
`ifndef VIRTUAL_IRQ_PRIORITY_CONTROLLER_UNIT_MACROS_SVH
`define VIRTUAL_IRQ_PRIORITY_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define VIPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vipc check failed");

// next-cycle implication, disabled while reset is low
`define VIPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vipc check failed");

`endif

/* rtl/vipc_pkg.sv */
// Types, codes and helpers of the virtual IRQ priority controller
package vipc_pkg;

  localparam int unsigned LINE_NUM_W = 5;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned NIBBLE_W   = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ACT_W      = 2;

  // operation codes
  localparam logic [OP_W-1:0] OP_ASSERT   = 3'd0;
  localparam logic [OP_W-1:0] OP_DEASSERT = 3'd1;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd2;
  localparam logic [OP_W-1:0] OP_EXECUTE  = 3'd3;
  localparam logic [OP_W-1:0] OP_WAIT     = 3'd4;
  localparam logic [OP_W-1:0] OP_WAKE     = 3'd5;
  localparam logic [OP_W-1:0] OP_TIMEOUT  = 3'd6;

  // action codes
  localparam logic [ACT_W-1:0] ACT_NONE   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_YIELD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PAUSE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_RESUME = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PRI_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRI_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LINES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_YLIMIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DWAIT  = 3'd4;

  localparam logic [7:0]        YLIMIT_RST = 8'd100;
  localparam logic [5:0]        LINES_RST  = 6'd32;
  localparam logic [WORD_W-1:0] DWAIT_RST  = 64'd1000000000;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic                  fin;
    logic                  have;
    logic [LINE_NUM_W-1:0] pick;
  } scan_sts_t;

  // nibble of a packed priority word
  function automatic logic [NIBBLE_W-1:0] get_nibble(input logic [WORD_W-1:0] word,
                                                     input logic [3:0] sel);
    get_nibble = word[sel*NIBBLE_W +: NIBBLE_W];
  endfunction

endpackage

/* rtl/vipc_scan.sv */
// Iterative priority scan: one line vs the running best per cycle while stepped
module vipc_scan #(
  parameter int unsigned MAX_LINES     = 32,
  parameter int unsigned PRIORITY_BITS = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vipc_pkg::scan_ctl_t     ctl_i,
  input  logic [5:0]              n_lines_i,
  input  logic [MAX_LINES-1:0]    asserted_i,
  input  logic [63:0]             pri_lo_i,
  input  logic [63:0]             pri_hi_i,
  output vipc_pkg::scan_sts_t     sts_o
);
  import vipc_pkg::*;

  localparam int unsigned LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_LINES + 1);

  logic [CNT_W-1:0]         idx_q, idx_d;
  logic [PRIORITY_BITS-1:0] best_q, best_d;
  logic [LINE_W-1:0]        pick_q, pick_d;
  logic                     have_q, have_d;

  logic                     fin;
  logic [LINE_NUM_W-1:0]    line5;
  logic [NIBBLE_W-1:0]      nib;
  logic [PRIORITY_BITS-1:0] prio;

  assign fin   = 6'(idx_q) >= n_lines_i;
  assign line5 = LINE_NUM_W'(idx_q);
  assign nib   = get_nibble(line5[4] ? pri_hi_i : pri_lo_i, line5[3:0]);
  assign prio  = nib[PRIORITY_BITS-1:0];

  always_comb begin
    idx_d  = idx_q;
    best_d = best_q;
    pick_d = pick_q;
    have_d = have_q;
    if (ctl_i.start) begin
      idx_d  = '0;
      best_d = '0;
      have_d = 1'b0;
    end else if (ctl_i.step && !fin) begin
      // strict compare keeps the lowest index on ties and skips priority zero
      if (asserted_i[idx_q[LINE_W-1:0]] && (prio > best_q)) begin
        best_d = prio;
        pick_d = idx_q[LINE_W-1:0];
        have_d = 1'b1;
      end
      idx_d = idx_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      best_q <= '0;
      pick_q <= '0;
      have_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      best_q <= best_d;
      pick_q <= pick_d;
      have_q <= have_d;
    end
  end

  assign sts_o.fin  = fin;
  assign sts_o.have = have_q;
  assign sts_o.pick = LINE_NUM_W'(pick_q);

endmodule

/* rtl/virtual_irq_priority_controller_unit.sv */
// Virtual IRQ line table for one vCPU: sequencer, line state, reason memory and result register
//
// One operation word is taken at a time; in_stall_o stays high from acceptance until the
// result is loaded into the output register. Each word passes from S_DISP to S_OUT, where
// the result is loaded. An execute scans the active lines through a shared priority
// comparator at one line per cycle in S_SCAN, then takes the picked line's reason in
// S_PICK; S_PICK is skipped when no line is found. A deassert or clear of a line in range
// takes its reason from the memory in S_RDRSN before S_OUT; every other operation, an
// execute with nothing to do included, goes from S_DISP to S_OUT. The next word can be taken the
// cycle after the load. A held result does not block the next word, but a new result waits
// while the output is stalled. Line reasons live in a single-port registered-read memory;
// per-line valid bits make unwritten entries read as zero, so no clearing pass follows reset.
// Configuration writes are always ready and must only be issued while the block is idle.
module virtual_irq_priority_controller_unit #(
  parameter int unsigned MAX_LINES     = 32,
  parameter int unsigned PRIORITY_BITS = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // operation channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [vipc_pkg::OP_W-1:0]      operation_i,
  input  logic [vipc_pkg::LINE_NUM_W-1:0] line_number_i,
  input  logic [63:0]                    cause_word_i,
  input  logic                           hook_ok_i,
  input  logic                           interruptible_i,
  input  logic                           platform_pending_i,
  input  logic [63:0]                    wait_ns_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           done_res_o,
  output logic                           found_o,
  output logic [vipc_pkg::LINE_NUM_W-1:0] selected_line_o,
  output logic [63:0]                    line_cause_o,
  output logic [vipc_pkg::ACT_W-1:0]     action_o,
  output logic [63:0]                    timer_ns_o,
  output logic                           waiting_o,
  // configuration write channel
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vipc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                    cfg_data_i
);
  import vipc_pkg::*;

  localparam int unsigned LINE_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_LINES + 1);
  localparam logic [5:0]       MAX_L6  = 6'(MAX_LINES);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_RDRSN = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  // configuration
  logic [63:0] pri_lo_q, pri_lo_d, pri_hi_q, pri_hi_d, dwait_q, dwait_d;
  logic [5:0]  lines_q, lines_d;
  logic [7:0]  ylim_q, ylim_d;

  // latched operation word
  logic [OP_W-1:0]       op_q;
  logic [LINE_NUM_W-1:0] line_q;
  logic [63:0]           cause_q, wns_q;
  logic                  hook_q, intr_q, plat_q;

  // line and vCPU state
  logic [MAX_LINES-1:0] asrt_q, asrt_d;
  logic [MAX_LINES-1:0] rvld_q, rvld_d;
  logic [CNT_W-1:0]     pend_q, pend_d;
  logic [7:0]           yield_q, yield_d;
  logic                 wait_q, wait_d;

  // staged result
  logic                  r_done_q, r_done_d, r_found_q, r_found_d;
  logic [LINE_NUM_W-1:0] r_sel_q, r_sel_d;
  logic [63:0]           r_lc_q, r_lc_d, r_tmr_q, r_tmr_d;
  logic [ACT_W-1:0]      r_act_q, r_act_d;

  // output register
  logic                  out_vld_q, out_vld_d;
  logic                  o_done_q, o_found_q, o_wait_q;
  logic [LINE_NUM_W-1:0] o_sel_q;
  logic [63:0]           o_lc_q, o_tmr_q;
  logic [ACT_W-1:0]      o_act_q;

  // reason memory
  logic [63:0]       rsn_mem [MAX_LINES];
  logic [63:0]       mem_rdata_q;
  logic              mem_we, mem_re;
  logic [LINE_W-1:0] mem_raddr;
  logic              rd_vld_q, rd_vld_d;

  logic [5:0]        active;
  logic              in_range, in_acc, out_load;
  logic [LINE_W-1:0] lidx, pidx;
  logic [63:0]       rd_word;

  scan_ctl_t scan_ctl;
  scan_sts_t scan_sts;

  assign active   = (lines_q > MAX_L6) ? MAX_L6 : lines_q;
  assign in_range = {1'b0, line_q} < active;
  assign lidx     = line_q[LINE_W-1:0];
  assign pidx     = scan_sts.pick[LINE_W-1:0];
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_load = (state_q == S_OUT) && (!out_vld_q || !out_stall_i);
  assign rd_word  = rd_vld_q ? mem_rdata_q : '0;

  vipc_scan #(
    .MAX_LINES    (MAX_LINES),
    .PRIORITY_BITS(PRIORITY_BITS)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .n_lines_i (active),
    .asserted_i(asrt_q),
    .pri_lo_i  (pri_lo_q),
    .pri_hi_i  (pri_hi_q),
    .sts_o     (scan_sts)
  );

  // configuration writes
  always_comb begin
    pri_lo_d = pri_lo_q;
    pri_hi_d = pri_hi_q;
    lines_d  = lines_q;
    ylim_d   = ylim_q;
    dwait_d  = dwait_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PRI_LO: pri_lo_d = cfg_data_i;
        CFG_PRI_HI: pri_hi_d = cfg_data_i;
        CFG_LINES:  lines_d  = cfg_data_i[5:0];
        CFG_YLIMIT: ylim_d   = cfg_data_i[7:0];
        CFG_DWAIT:  dwait_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    asrt_d    = asrt_q;
    rvld_d    = rvld_q;
    pend_d    = pend_q;
    yield_d   = yield_q;
    wait_d    = wait_q;
    r_done_d  = r_done_q;
    r_found_d = r_found_q;
    r_sel_d   = r_sel_q;
    r_lc_d    = r_lc_q;
    r_act_d   = r_act_q;
    r_tmr_d   = r_tmr_q;
    scan_ctl  = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = lidx;
    rd_vld_d  = rd_vld_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_DISP;
      end

      S_DISP: begin
        r_done_d  = 1'b0;
        r_found_d = 1'b0;
        r_sel_d   = '0;
        r_lc_d    = '0;
        r_act_d   = ACT_NONE;
        r_tmr_d   = '0;
        state_d   = S_OUT;
        case (op_q)
          OP_ASSERT: begin
            r_sel_d = line_q;
            if (intr_q && in_range && !asrt_q[lidx] && hook_q) begin
              asrt_d[lidx] = 1'b1;
              rvld_d[lidx] = 1'b1;
              mem_we       = 1'b1;
              if (pend_q < MAX_CNT) pend_d = pend_q + CNT_W'(1);
              r_lc_d   = cause_q;
              r_done_d = 1'b1;
              yield_d  = '0;
              if (wait_q) begin
                wait_d  = 1'b0;
                r_act_d = ACT_RESUME;
              end
            end
          end
          OP_DEASSERT, OP_CLEAR: begin
            r_sel_d = line_q;
            if (in_range) begin
              mem_re   = 1'b1;
              rd_vld_d = rvld_q[lidx];
              state_d  = S_RDRSN;
            end
          end
          OP_EXECUTE: begin
            if (intr_q && (pend_q != '0)) begin
              pend_d         = pend_q - CNT_W'(1);
              scan_ctl.start = 1'b1;
              state_d        = S_SCAN;
            end
          end
          OP_WAIT: begin
            if ((pend_q != '0) || plat_q) begin
              yield_d  = '0;
              r_done_d = 1'b1;
            end else if (yield_q < ylim_q) begin
              yield_d  = yield_q + 8'd1;
              r_act_d  = ACT_YIELD;
              r_done_d = 1'b1;
            end else if (!wait_q) begin
              wait_d   = 1'b1;
              r_act_d  = ACT_PAUSE;
              r_tmr_d  = (wns_q != '0) ? wns_q : dwait_q;
              r_done_d = 1'b1;
            end
          end
          OP_WAKE, OP_TIMEOUT: begin
            if (op_q == OP_WAKE) yield_d = '0;
            if (wait_q) begin
              wait_d   = 1'b0;
              r_act_d  = ACT_RESUME;
              r_done_d = 1'b1;
            end
          end
          default: ;
        endcase
      end

      S_SCAN: begin
        if (!scan_sts.fin) begin
          scan_ctl.step = 1'b1;
        end else if (scan_sts.have) begin
          mem_re    = 1'b1;
          mem_raddr = pidx;
          rd_vld_d  = rvld_q[pidx];
          state_d   = S_PICK;
        end else begin
          state_d = S_OUT;
        end
      end

      S_RDRSN: begin
        r_lc_d       = rd_word;
        r_done_d     = 1'b1;
        asrt_d[lidx] = 1'b0;
        rvld_d[lidx] = 1'b0;  // reason reads as zero from now on
        state_d      = S_OUT;
      end

      S_PICK: begin
        r_done_d  = 1'b1;
        r_found_d = 1'b1;
        r_sel_d   = scan_sts.pick;
        r_lc_d    = rd_word;
        if (hook_q) begin
          asrt_d[pidx] = 1'b0;
        end else if (pend_q < MAX_CNT) begin
          pend_d = pend_q + CNT_W'(1);  // refused: give the execute back
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) out_vld_d = 1'b1;
    else if (!out_stall_i) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      pri_lo_q  <= '0;
      pri_hi_q  <= '0;
      lines_q   <= LINES_RST;
      ylim_q    <= YLIMIT_RST;
      dwait_q   <= DWAIT_RST;
      asrt_q    <= '0;
      rvld_q    <= '0;
      pend_q    <= '0;
      yield_q   <= '0;
      wait_q    <= 1'b0;
      out_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      pri_lo_q  <= pri_lo_d;
      pri_hi_q  <= pri_hi_d;
      lines_q   <= lines_d;
      ylim_q    <= ylim_d;
      dwait_q   <= dwait_d;
      asrt_q    <= asrt_d;
      rvld_q    <= rvld_d;
      pend_q    <= pend_d;
      yield_q   <= yield_d;
      wait_q    <= wait_d;
      out_vld_q <= out_vld_d;
      rd_vld_q  <= rd_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= operation_i;
      line_q  <= line_number_i;
      cause_q <= cause_word_i;
      hook_q  <= hook_ok_i;
      intr_q  <= interruptible_i;
      plat_q  <= platform_pending_i;
      wns_q   <= wait_ns_i;
    end
    r_done_q  <= r_done_d;
    r_found_q <= r_found_d;
    r_sel_q   <= r_sel_d;
    r_lc_q    <= r_lc_d;
    r_act_q   <= r_act_d;
    r_tmr_q   <= r_tmr_d;
    if (out_load) begin
      o_done_q  <= r_done_q;
      o_found_q <= r_found_q;
      o_sel_q   <= r_sel_q;
      o_lc_q    <= r_lc_q;
      o_act_q   <= r_act_q;
      o_tmr_q   <= r_tmr_q;
      o_wait_q  <= wait_q;
    end
  end

  // reason memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) rsn_mem[lidx] <= cause_q;
    if (mem_re) mem_rdata_q <= rsn_mem[mem_raddr];
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_vld_q;
  assign done_res_o      = o_done_q;
  assign found_o         = o_found_q;
  assign selected_line_o = o_sel_q;
  assign line_cause_o    = o_lc_q;
  assign action_o        = o_act_q;
  assign timer_ns_o      = o_tmr_q;
  assign waiting_o       = o_wait_q;

endmodule

/* rtl/vipc_checker.sv */
// Port-level checks of the virtual IRQ controller, bound to the top level
`include "virtual_irq_priority_controller_unit_macros.svh"

module vipc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            done_res_o,
  input logic                            found_o,
  input logic [vipc_pkg::LINE_NUM_W-1:0] selected_line_o,
  input logic [63:0]                     line_cause_o,
  input logic [vipc_pkg::ACT_W-1:0]      action_o,
  input logic [63:0]                     timer_ns_o,
  input logic                            waiting_o
);
  import vipc_pkg::*;

  // a stalled word holds
  `VIPC_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(line_cause_o) && $stable(timer_ns_o) && $stable(selected_line_o))

  // one operation in flight: busy right after an accept
  `VIPC_ASSERT_NXT(a_busy_after_acc, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // timer only with a pause, and a pause leaves the vCPU waiting
  `VIPC_ASSERT_IMP(a_timer_pause, clk_i, rst_ni, out_valid_o && (action_o != ACT_PAUSE), timer_ns_o == '0)
  `VIPC_ASSERT_IMP(a_wait_flag, clk_i, rst_ni, out_valid_o && ((action_o == ACT_PAUSE) || (action_o == ACT_RESUME)), waiting_o == (action_o == ACT_PAUSE))

  // a selected line always counts as done
  `VIPC_ASSERT_IMP(a_found_done, clk_i, rst_ni, out_valid_o && found_o, done_res_o)

endmodule

bind virtual_irq_priority_controller_unit vipc_checker u_vipc_checker (.*);
